@@ rtl/rbb_pkg.sv @@
package rbb_pkg;

  localparam int PRICE_W = 32;
  localparam int TIME_W  = 63;
  localparam int SIZE_W  = 31;
  localparam int CNT_W   = 20;
  localparam int MODE_W  = 2;
  localparam int TREND_W = 2;
  localparam int WIDE_W  = 35;

  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 128;
  localparam int M_TUSER_W = 2;

  localparam int DIV_DVD_W = 33;
  localparam int DIV_DVS_W = 32;

  localparam int DEF_TOTAL_BRICK_CAP = 65536;
  localparam int DEF_BRICKS_PER_ITEM = 64;

  localparam logic [MODE_W-1:0] MODE_COMMIT      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROVISIONAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;

  localparam logic [TREND_W-1:0] TREND_NONE = 2'd0;
  localparam logic [TREND_W-1:0] TREND_UP   = 2'd1;
  localparam logic [TREND_W-1:0] TREND_DOWN = 2'd2;

  typedef struct packed {
    logic load_item;
    logic clear_state;
    logic seed_start;
    logic seed_store;
    logic pass_begin;
    logic step;
    logic pass1_end;
    logic set_trunc;
    logic out_load;
    logic commit_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              seeded;
    logic              b_zero;
    logic              div_done;
    logic              brick_due;
    logic              n_ge_limit;
    logic              n_ge_bpi;
    logic              n_zero;
    logic              emit_last;
    logic              out_free;
  } ctrl_stat_t;

endpackage

@@ rtl/rbb_div.sv @@
module rbb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rbb_pkg::DIV_DVD_W-1:0] dividend,
  input  logic [rbb_pkg::DIV_DVS_W-1:0] divisor,
  output logic                          done,
  output logic [rbb_pkg::DIV_DVS_W-1:0] remainder
);

  localparam int DVD_W = rbb_pkg::DIV_DVD_W;
  localparam int DVS_W = rbb_pkg::DIV_DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign shifted   = {rem, dvd[DVD_W-1]};
  assign trial     = shifted - {1'b0, dvs};
  assign fits      = shifted >= {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

endmodule

@@ rtl/rbb_datapath.sv @@
module rbb_datapath #(
  parameter int TOTAL_BRICK_CAP = rbb_pkg::DEF_TOTAL_BRICK_CAP,
  parameter int BRICKS_PER_ITEM = rbb_pkg::DEF_BRICKS_PER_ITEM
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rbb_pkg::ctrl_cmd_t                 cmd,
  output rbb_pkg::ctrl_stat_t                stat,
  input  logic                               brick_height_wr_en,
  input  logic [rbb_pkg::SIZE_W-1:0]         brick_height_wr_data,
  input  logic [rbb_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [rbb_pkg::PRICE_W-1:0] in_price,
  input  logic [rbb_pkg::TIME_W-1:0]         in_time,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_up,
  output logic signed [rbb_pkg::PRICE_W-1:0] out_open,
  output logic signed [rbb_pkg::PRICE_W-1:0] out_close,
  output logic [rbb_pkg::TIME_W-1:0]         out_time,
  output logic                               out_prov,
  output logic                               out_last,
  output logic                               out_trunc
);

  localparam int PW  = rbb_pkg::PRICE_W;
  localparam int WW  = rbb_pkg::WIDE_W;
  localparam int SW  = rbb_pkg::SIZE_W;
  localparam int CW  = rbb_pkg::CNT_W;
  localparam int TW  = rbb_pkg::TREND_W;
  localparam int N_W = $clog2(BRICKS_PER_ITEM + 1);
  localparam logic [CW:0]    CAP_L = (CW + 1)'(TOTAL_BRICK_CAP);
  localparam logic [N_W-1:0] BPI_L = N_W'(BRICKS_PER_ITEM);

  logic [SW-1:0]               brick_height;
  logic [rbb_pkg::MODE_W-1:0]  mode_q;
  logic signed [PW-1:0]        price_q;
  logic [rbb_pkg::TIME_W-1:0]  time_q;
  logic signed [PW-1:0]        last_close;
  logic [TW-1:0]               trend;
  logic                        seeded;
  logic [CW-1:0]               committed_count;
  logic signed [PW-1:0]        wcl;
  logic [TW-1:0]               wdir;
  logic [N_W-1:0]              n;
  logic [N_W-1:0]              ntotal;
  logic                        trunc_q;

  logic signed [WW-1:0] p_w, cl_w, b_w;
  logic signed [WW-1:0] cl_pb, cl_p2b, cl_mb, cl_m2b;
  logic                 due;
  logic                 b_up;
  logic signed [WW-1:0] b_open_w, b_close_w;
  logic [TW-1:0]        dir_new;

  logic [CW:0]          used;
  logic                 is_commit;

  logic [rbb_pkg::DIV_DVD_W-1:0] div_dvd;
  logic [rbb_pkg::DIV_DVS_W-1:0] div_dvs;
  logic [rbb_pkg::DIV_DVS_W-1:0] div_rem;
  logic                          div_done;
  logic [PW-1:0]                 abs_p;
  logic [rbb_pkg::DIV_DVD_W-1:0] seed_diff;
  logic [PW-1:0]                 seed_mag;
  logic [PW-1:0]                 mag_lim;
  logic [PW-1:0]                 seed_fix;
  logic signed [PW-1:0]          seed_val;

  assign p_w    = WW'(price_q);
  assign cl_w   = WW'(wcl);
  assign b_w    = WW'({1'b0, brick_height});
  assign cl_pb  = cl_w + b_w;
  assign cl_p2b = cl_pb + b_w;
  assign cl_mb  = cl_w - b_w;
  assign cl_m2b = cl_mb - b_w;

  always_comb begin
    due       = 1'b0;
    b_up      = 1'b0;
    b_open_w  = cl_w;
    b_close_w = cl_w;
    if (wdir != rbb_pkg::TREND_DOWN) begin
      priority if (p_w >= cl_pb) begin
        due       = 1'b1;
        b_up      = 1'b1;
        b_close_w = cl_pb;
      end else if (wdir == rbb_pkg::TREND_UP && p_w <= cl_m2b) begin
        due       = 1'b1;
        b_open_w  = cl_mb;
        b_close_w = cl_m2b;
      end else if (wdir == rbb_pkg::TREND_NONE && p_w <= cl_mb) begin
        due       = 1'b1;
        b_close_w = cl_mb;
      end else begin
        due = 1'b0;
      end
    end else begin
      priority if (p_w <= cl_mb) begin
        due       = 1'b1;
        b_close_w = cl_mb;
      end else if (p_w >= cl_p2b) begin
        due       = 1'b1;
        b_up      = 1'b1;
        b_open_w  = cl_pb;
        b_close_w = cl_p2b;
      end else begin
        due = 1'b0;
      end
    end
    dir_new = b_up ? rbb_pkg::TREND_UP : rbb_pkg::TREND_DOWN;
  end

  assign is_commit = (mode_q == rbb_pkg::MODE_COMMIT);
  assign used      = (is_commit ? {1'b0, committed_count} : '0) + (CW + 1)'(n);

  assign abs_p     = price_q[PW-1] ? PW'(-price_q) : PW'(price_q);
  assign div_dvd   = {abs_p, 1'b0} + rbb_pkg::DIV_DVD_W'(brick_height);
  assign div_dvs   = {brick_height, 1'b0};
  assign seed_diff = div_dvd - {1'b0, div_rem};
  assign seed_mag  = seed_diff[rbb_pkg::DIV_DVD_W-1:1];
  assign mag_lim   = price_q[PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign seed_fix  = (seed_mag > mag_lim) ? seed_mag - PW'(brick_height) : seed_mag;
  assign seed_val  = price_q[PW-1] ? -$signed(seed_fix) : $signed(seed_fix);

  rbb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.seed_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    stat            = '0;
    stat.mode       = mode_q;
    stat.seeded     = seeded;
    stat.b_zero     = (brick_height == '0);
    stat.div_done   = div_done;
    stat.brick_due  = due;
    stat.n_ge_limit = (used >= CAP_L);
    stat.n_ge_bpi   = (n >= BPI_L);
    stat.n_zero     = (n == '0);
    stat.emit_last  = (n + N_W'(1) == ntotal);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brick_height    <= '0;
      last_close      <= '0;
      trend           <= rbb_pkg::TREND_NONE;
      seeded          <= 1'b0;
      committed_count <= '0;
    end else begin
      if (brick_height_wr_en) begin
        brick_height <= brick_height_wr_data;
      end
      if ((brick_height_wr_en && brick_height_wr_data != brick_height) ||
          cmd.clear_state) begin
        last_close      <= '0;
        trend           <= rbb_pkg::TREND_NONE;
        seeded          <= 1'b0;
        committed_count <= '0;
      end else if (cmd.seed_store) begin
        last_close <= seed_val;
        trend      <= rbb_pkg::TREND_NONE;
        seeded     <= 1'b1;
      end else if (cmd.commit_end && is_commit) begin
        last_close      <= PW'(b_close_w);
        trend           <= dir_new;
        committed_count <= committed_count + CW'(ntotal);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q  <= in_mode;
      price_q <= in_price;
      time_q  <= in_time;
    end
    if (cmd.pass_begin || cmd.pass1_end) begin
      wcl <= last_close;
      wdir <= trend;
    end else if (cmd.step) begin
      wcl  <= PW'(b_close_w);
      wdir <= dir_new;
    end
    if (cmd.pass1_end) begin
      ntotal  <= n;
      trunc_q <= cmd.set_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.pass_begin || cmd.pass1_end) begin
      n <= '0;
    end else if (cmd.step) begin
      n <= n + N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_up    <= b_up;
      out_open  <= PW'(b_open_w);
      out_close <= PW'(b_close_w);
      out_time  <= time_q;
      out_prov  <= (mode_q == rbb_pkg::MODE_PROVISIONAL);
      out_last  <= stat.emit_last;
      out_trunc <= trunc_q;
    end
  end

endmodule

@@ rtl/rbb_ctrl.sv @@
module rbb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbb_pkg::ctrl_stat_t stat,
  output rbb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SEED     = 5'b00100,
    ST_PASS1    = 5'b01000,
    ST_PASS2    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.mode == rbb_pkg::MODE_CLEAR) begin
          cmd.clear_state = 1'b1;
          state_next      = ST_IDLE;
        end else if (stat.mode == rbb_pkg::MODE_UNUSED || stat.b_zero) begin
          state_next = ST_IDLE;
        end else if (!stat.seeded) begin
          if (stat.mode == rbb_pkg::MODE_PROVISIONAL) begin
            state_next = ST_IDLE;
          end else begin
            cmd.seed_start = 1'b1;
            state_next     = ST_SEED;
          end
        end else begin
          cmd.pass_begin = 1'b1;
          state_next     = ST_PASS1;
        end
      end
      ST_SEED: begin
        if (stat.div_done) begin
          cmd.seed_store = 1'b1;
          state_next     = ST_DISPATCH;
        end
      end
      ST_PASS1: begin
        priority if (stat.n_ge_limit || !stat.brick_due) begin
          cmd.pass1_end = 1'b1;
          state_next    = stat.n_zero ? ST_IDLE : ST_PASS2;
        end else if (stat.n_ge_bpi) begin
          cmd.pass1_end = 1'b1;
          cmd.set_trunc = 1'b1;
          state_next    = ST_PASS2;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_PASS2: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.step     = 1'b1;
          if (stat.emit_last) begin
            cmd.commit_end = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/renko_brick_builder_top.sv @@
// Renko brick builder. Input transfers carry one price observation each:
// s_tdata holds price and time stamp, s_tuser holds the mode (commit,
// provisional query or clear). Each input transfer causes zero or more
// output transfers, one per brick, with m_tlast on the final brick of that
// input. The brick size register is written through brick_height_wr_en and
// brick_height_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. A new value clears the state.
// An input transfer is taken only while the controller is idle. Processing
// runs two passes over the brick sequence through one compare unit: a
// counting pass that fixes the run length and truncation, then an emitting
// pass that sends the bricks in order. The first commit after a reset, a
// clear or a brick size change also runs a bit-serial divider to place the
// seed level. The result register lets the next input transfer be taken
// while the last brick still waits; when the receiver stalls, emission
// pauses and nothing is lost. Reset clears the brick size to zero, which
// disables output.
module renko_brick_builder_top #(
  parameter int TOTAL_BRICK_CAP = rbb_pkg::DEF_TOTAL_BRICK_CAP,
  parameter int BRICKS_PER_ITEM = rbb_pkg::DEF_BRICKS_PER_ITEM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            brick_height_wr_en,
  input  logic [rbb_pkg::SIZE_W-1:0]      brick_height_wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: price[31:0], time_stamp[94:32], zero pad[95].
  input  logic [rbb_pkg::S_TDATA_W-1:0]   s_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [rbb_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: brick_up[0], brick_open[32:1], brick_close[64:33],
  // brick_time[127:65].
  output logic [rbb_pkg::M_TDATA_W-1:0]   m_tdata,
  // Fields from bit 0: is_provisional[0], truncated[1].
  output logic [rbb_pkg::M_TUSER_W-1:0]   m_tuser,
  output logic                            m_tlast
);

  localparam int PW = rbb_pkg::PRICE_W;
  localparam int TW = rbb_pkg::TIME_W;

  rbb_pkg::ctrl_cmd_t  cmd;
  rbb_pkg::ctrl_stat_t stat;

  logic                 out_up;
  logic signed [PW-1:0] out_open;
  logic signed [PW-1:0] out_close;
  logic [TW-1:0]        out_time;
  logic                 out_prov;
  logic                 out_trunc;

  rbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbb_datapath #(
    .TOTAL_BRICK_CAP (TOTAL_BRICK_CAP),
    .BRICKS_PER_ITEM (BRICKS_PER_ITEM)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .brick_height_wr_en   (brick_height_wr_en),
    .brick_height_wr_data (brick_height_wr_data),
    .in_mode              (s_tuser[rbb_pkg::MODE_W-1:0]),
    .in_price             (s_tdata[PW-1:0]),
    .in_time              (s_tdata[PW+TW-1:PW]),
    .out_ready            (m_tready),
    .out_valid            (m_tvalid),
    .out_up               (out_up),
    .out_open             (out_open),
    .out_close            (out_close),
    .out_time             (out_time),
    .out_prov             (out_prov),
    .out_last             (m_tlast),
    .out_trunc            (out_trunc)
  );

  assign m_tdata = {out_time, out_close, out_open, out_up};
  assign m_tuser = {out_trunc, out_prov};

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("brick loaded over an untaken brick");

  a_replay_matches_count: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.brick_due)
    else $error("emitting pass found no brick where the counting pass did");

  a_brick_direction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_up ? (out_close > out_open) : (out_close < out_open)))
    else $error("brick close does not agree with its direction");
`endif

endmodule

@@ bench/renko_brick_builder_top_tb.sv @@
module renko_brick_builder_top_tb;

  localparam int BRICK_CAP = rbb_pkg::DEF_TOTAL_BRICK_CAP;
  localparam int RUN_LIMIT = rbb_pkg::DEF_BRICKS_PER_ITEM;
  localparam int QUIET_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_RUNS = 15;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint PX_MAX = 64'sh7FFF_FFFF;
  localparam longint PX_MIN = -64'sh8000_0000;

  typedef struct {
    logic                        up;
    logic [rbb_pkg::PRICE_W-1:0] open_px;
    logic [rbb_pkg::PRICE_W-1:0] close_px;
    logic [rbb_pkg::TIME_W-1:0]  stamp;
    logic                        prov;
    logic                        last;
    logic                        trunc;
  } brick_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          brick_height_wr_en = 1'b0;
  logic [rbb_pkg::SIZE_W-1:0]    brick_height_wr_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rbb_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [rbb_pkg::S_TUSER_W-1:0] s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rbb_pkg::M_TDATA_W-1:0] m_tdata;
  logic [rbb_pkg::M_TUSER_W-1:0] m_tuser;
  logic                          m_tlast;

  brick_t                      due_bricks[$];
  logic [rbb_pkg::SIZE_W-1:0]  chart_size;
  longint                      chart_close;
  logic [rbb_pkg::TREND_W-1:0] chart_trend;
  bit                          chart_seeded;
  int                          chart_count;

  int     src_idle = 0;
  int     sink_idle = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     mismatches = 0;
  int     items_sent = 0;
  int     bricks_seen = 0;
  longint cycles = 0;

  renko_brick_builder_top #(
    .TOTAL_BRICK_CAP(BRICK_CAP),
    .BRICKS_PER_ITEM(RUN_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .brick_height_wr_en(brick_height_wr_en),
    .brick_height_wr_data(brick_height_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic void chart_clear();
    chart_close = 0;
    chart_trend = rbb_pkg::TREND_NONE;
    chart_seeded = 1'b0;
    chart_count = 0;
  endfunction

  // Nearest multiple of the brick size, halves away from zero, pulled one
  // brick toward zero when it falls outside the 32-bit price range.
  function automatic longint nearest_level(longint p, longint b);
    longint mag, q, s;
    mag = (p < 0) ? -p : p;
    q = (2 * mag + b) / (2 * b);
    s = (p < 0) ? -q * b : q * b;
    if (s > PX_MAX) s -= b;
    if (s < PX_MIN) s += b;
    return s;
  endfunction

  function automatic void predict_bricks(logic [rbb_pkg::MODE_W-1:0] mode,
                                         logic [rbb_pkg::PRICE_W-1:0] price,
                                         logic [rbb_pkg::TIME_W-1:0] stamp);
    longint p, b, cl, o, c, allowed;
    logic [rbb_pkg::TREND_W-1:0] dir;
    logic up, due, prov, trunc;
    brick_t run[$];
    brick_t br;
    p = longint'($signed(price));
    b = longint'(chart_size);
    prov = (mode == rbb_pkg::MODE_PROVISIONAL);
    trunc = 1'b0;
    if (mode == rbb_pkg::MODE_CLEAR) begin
      chart_clear();
      return;
    end
    if (mode == rbb_pkg::MODE_UNUSED || b == 0) return;
    if (prov) begin
      if (!chart_seeded) return;
      allowed = BRICK_CAP;
    end else begin
      if (!chart_seeded) begin
        chart_close = nearest_level(p, b);
        chart_trend = rbb_pkg::TREND_NONE;
        chart_seeded = 1'b1;
      end
      allowed = (chart_count >= BRICK_CAP) ? 0 : BRICK_CAP - chart_count;
    end
    cl = chart_close;
    dir = chart_trend;
    while (run.size() < allowed) begin
      due = 1'b1;
      up = 1'b0;
      o = 0;
      c = 0;
      if (dir != rbb_pkg::TREND_DOWN) begin
        if (p >= cl + b) begin
          up = 1'b1; o = cl; c = cl + b;
        end else if (dir == rbb_pkg::TREND_UP && p <= cl - 2 * b) begin
          o = cl - b; c = cl - 2 * b;
        end else if (dir == rbb_pkg::TREND_NONE && p <= cl - b) begin
          o = cl; c = cl - b;
        end else begin
          due = 1'b0;
        end
      end else begin
        if (p <= cl - b) begin
          o = cl; c = cl - b;
        end else if (p >= cl + 2 * b) begin
          up = 1'b1; o = cl + b; c = cl + 2 * b;
        end else begin
          due = 1'b0;
        end
      end
      if (!due) break;
      if (run.size() >= RUN_LIMIT) begin
        trunc = 1'b1;
        break;
      end
      cl = c;
      dir = up ? rbb_pkg::TREND_UP : rbb_pkg::TREND_DOWN;
      br.up = up;
      br.open_px = o[rbb_pkg::PRICE_W-1:0];
      br.close_px = c[rbb_pkg::PRICE_W-1:0];
      br.stamp = stamp;
      br.prov = prov;
      br.last = 1'b0;
      br.trunc = 1'b0;
      run.insert(run.size(), br);
      if (!prov) begin
        chart_close = cl;
        chart_trend = dir;
        chart_count++;
      end
    end
    foreach (run[i]) begin
      run[i].trunc = trunc;
      run[i].last = (i == run.size() - 1);
      due_bricks.insert(due_bricks.size(), run[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : sink
    brick_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bricks_seen++;
        if (due_bricks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected brick, expected none, actual %0h %0h %0b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = due_bricks.pop_front();
          check_field("brick_up", want.up, m_tdata[0]);
          check_field("brick_open", want.open_px, m_tdata[32:1]);
          check_field("brick_close", want.close_px, m_tdata[64:33]);
          check_field("brick_time", want.stamp, m_tdata[127:65]);
          check_field("is_provisional", want.prov, m_tuser[0]);
          check_field("truncated", want.trunc, m_tuser[1]);
          check_field("last_of_run", want.last, m_tlast);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= sink_idle);
      end
    end
  end

  task automatic send_item(logic [rbb_pkg::MODE_W-1:0] mode, longint price,
                           logic [rbb_pkg::TIME_W-1:0] stamp);
    logic [rbb_pkg::PRICE_W-1:0] px;
    if (price > PX_MAX) price = PX_MAX;
    if (price < PX_MIN) price = PX_MIN;
    px = price[rbb_pkg::PRICE_W-1:0];
    while ($urandom_range(99, 0) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, stamp, px};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_bricks(mode, px, stamp);
    items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_bricks.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_brick_height(logic [rbb_pkg::SIZE_W-1:0] v);
    settle();
    brick_height_wr_en <= 1'b1;
    brick_height_wr_data <= v;
    @(posedge clk);
    brick_height_wr_en <= 1'b0;
    if (v != chart_size) chart_clear();
    chart_size = v;
  endtask

  function automatic logic [rbb_pkg::TIME_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return r[rbb_pkg::TIME_W-1:0];
    endcase
  endfunction

  function automatic longint rand_px();
    case ($urandom_range(5, 0))
      0: return PX_MAX;
      1: return PX_MIN;
      default: return longint'($signed($urandom));
    endcase
  endfunction

  task automatic test_zero_size();
    send_item(rbb_pkg::MODE_COMMIT, 123, 5);
    send_item(rbb_pkg::MODE_PROVISIONAL, 123, 6);
    send_item(rbb_pkg::MODE_COMMIT, -5, 7);
  endtask

  task automatic test_trend_rules();
    set_brick_height(10);
    send_item(rbb_pkg::MODE_PROVISIONAL, 50, 1);
    send_item(rbb_pkg::MODE_COMMIT, 15, 2);
    send_item(rbb_pkg::MODE_COMMIT, 45, 3);
    send_item(rbb_pkg::MODE_PROVISIONAL, 75, 4);
    send_item(rbb_pkg::MODE_COMMIT, 25, 5);
    send_item(rbb_pkg::MODE_COMMIT, 20, 6);
    send_item(rbb_pkg::MODE_COMMIT, 45, 7);
    send_item(rbb_pkg::MODE_UNUSED, 900, 8);
    send_item(rbb_pkg::MODE_COMMIT, 800, '0);
    send_item(rbb_pkg::MODE_PROVISIONAL, -2000, '1);
    send_item(rbb_pkg::MODE_CLEAR, 0, 9);
    send_item(rbb_pkg::MODE_COMMIT, -15, 10);
    send_item(rbb_pkg::MODE_COMMIT, -31, 11);
    send_item(rbb_pkg::MODE_COMMIT, -50, 12);
  endtask

  task automatic test_range_extremes();
    set_brick_height(31'h4000_0001);
    send_item(rbb_pkg::MODE_COMMIT, PX_MAX, 20);
    send_item(rbb_pkg::MODE_CLEAR, 0, 21);
    send_item(rbb_pkg::MODE_COMMIT, PX_MIN, 22);
    set_brick_height(31'h4000_0001);
    send_item(rbb_pkg::MODE_PROVISIONAL, PX_MAX, 23);
    set_brick_height(31'h7FFF_FFFF);
    send_item(rbb_pkg::MODE_COMMIT, PX_MIN, 24);
    send_item(rbb_pkg::MODE_COMMIT, PX_MAX, 25);
  endtask

  task automatic test_random_walk(int count, logic [rbb_pkg::SIZE_W-1:0] size);
    longint walk, b, price;
    int pick;
    set_brick_height(size);
    b = longint'(size);
    if ($urandom_range(1, 0)) walk = longint'($urandom_range(2000, 0)) - 1000;
    else walk = longint'($signed($urandom));
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        send_item(rbb_pkg::MODE_CLEAR, rand_px(), rand_stamp());
      end else if (pick < 7) begin
        send_item(rbb_pkg::MODE_UNUSED, rand_px(), rand_stamp());
      end else if (pick < 12) begin
        walk = rand_px();
        send_item(rbb_pkg::MODE_COMMIT, walk, rand_stamp());
      end else begin
        if (pick < 16) price = walk + (longint'($urandom_range(160, 0)) - 80) * b;
        else price = walk + (longint'($urandom_range(6, 0)) - 3) * b
                     + longint'($urandom_range(size, 0)) - b / 2;
        if (price > PX_MAX) price = PX_MAX;
        if (price < PX_MIN) price = PX_MIN;
        if (pick < 85) begin
          walk = price;
          send_item(rbb_pkg::MODE_COMMIT, price, rand_stamp());
        end else begin
          send_item(rbb_pkg::MODE_PROVISIONAL, price, rand_stamp());
        end
      end
    end
  endtask

  task automatic test_receiver_stall();
    longint lvl;
    set_brick_height(5);
    hold_req <= hold_req + 1;
    lvl = 0;
    send_item(rbb_pkg::MODE_COMMIT, lvl, rand_stamp());
    repeat (20) begin
      lvl = lvl + (longint'($urandom_range(16, 0)) - 8) * 5;
      send_item(rbb_pkg::MODE_COMMIT, lvl, rand_stamp());
    end
  endtask

  task automatic test_long_runs();
    longint lvl;
    set_brick_height(1);
    send_item(rbb_pkg::MODE_COMMIT, 0, 0);
    lvl = 0;
    for (int i = 0; i < LONG_RUNS; i++) begin
      send_item(rbb_pkg::MODE_COMMIT, lvl + 100, rbb_pkg::TIME_W'(i + 1));
      lvl += RUN_LIMIT;
    end
    send_item(rbb_pkg::MODE_PROVISIONAL, lvl - 300, rand_stamp());
    send_item(rbb_pkg::MODE_CLEAR, 0, rand_stamp());
    send_item(rbb_pkg::MODE_COMMIT, 5, rand_stamp());
    send_item(rbb_pkg::MODE_COMMIT, 8, rand_stamp());
  endtask

  initial begin
    chart_size = '0;
    chart_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle = 25;
    sink_idle = 82;
    test_zero_size();
    test_trend_rules();
    test_range_extremes();
    test_random_walk(35, rbb_pkg::SIZE_W'($urandom_range(8, 1)));
    test_random_walk(35, rbb_pkg::SIZE_W'($urandom_range(200, 9)));
    src_idle = 82;
    sink_idle = 25;
    test_receiver_stall();
    test_random_walk(35, rbb_pkg::SIZE_W'($urandom));
    test_random_walk(35, rbb_pkg::SIZE_W'($urandom_range(4, 1)));
    src_idle = 0;
    sink_idle = 0;
    test_random_walk(40, rbb_pkg::SIZE_W'($urandom_range(50, 1)));
    test_random_walk(40, rbb_pkg::SIZE_W'($urandom_range(3, 1)));
    test_long_runs();
    settle();
    $display("Run covered %0d input transfers and %0d brick transfers: trend rules, seeding,",
             items_sent, bricks_seen);
    $display("truncated long runs, range extremes and a long receiver stall.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
